/* design/pvef_pkg.sv */
// Shared types and constants of the Prewitt vertical-edge filter.
package pvef_pkg;

  // Pixel transfer into the filter
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  // Result transfer out of the filter
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_done;
  } result_t;

  // Classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [23:0] px;     // {blue, green, red}
    logic        emit;   // centre is interior, a result follows
    logic [11:0] row;    // centre row
    logic [9:0]  col;    // centre column
    logic        done;   // last interior centre of the frame
  } job_t;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_DATA_W = 12;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  // Smallest frame dimension the window supports
  localparam int MIN_DIM = 3;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Divide by three: floor(v * 683 / 2048) is exact for v below 2048
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int         RECIP3_SHIFT = 11;

endpackage

/* design/prewitt_vertical_edge_filter.sv */
// Prewitt vertical-edge filter: takes RGB pixels in raster order and gives,
// for every interior centre, |right column sum - left column sum| / 3 per
// channel with the centre's row and column; border centres give nothing.
// Throughput is one pixel per clock while pixel_stall is low: the line store is
// one 48-bit memory with one read and one write each cycle, and the back end is
// a three-stage pipeline (line store read, column sums, divide by three into
// the output register) that holds while a result is stalled. A four-entry
// queue sits between the counters and the back end so pixels keep being taken
// while a result waits, until the queue fills. The line store needs no
// clearing after reset; the first two rows read no stored data that reaches
// a result.
module prewitt_vertical_edge_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  input  pvef_pkg::pixel_t                    pixel,
  output logic                                pixel_stall,
  output logic                                result_valid,
  input  logic                                result_stall,
  output pvef_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [pvef_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import pvef_pkg::*;

  localparam int IDX_W = $clog2(MAX_WIDTH);
  localparam int QW    = IDX_W + $bits(job_t);

  logic [10:0] frame_width;
  logic [11:0] frame_height;

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  job_t             f_job;
  logic [IDX_W-1:0] f_idx;
  logic [QW-1:0]    q_head;
  job_t             q_job;
  logic [IDX_W-1:0] q_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  pvef_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .pixel_stall  (pixel_stall),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_full       (q_full),
    .push         (push),
    .job          (f_job),
    .idx          (f_idx)
  );

  pvef_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({f_idx, f_job}),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_head),
    .not_empty (q_valid)
  );

  assign q_job = q_head[$bits(job_t)-1:0];
  assign q_idx = q_head[QW-1:$bits(job_t)];

  pvef_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .q_idx        (q_idx),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* design/pvef_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
module pvef_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/pvef_front.sv */
// Front end: position counters, border classification and job push.
module pvef_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  input  pvef_pkg::pixel_t             pixel,
  output logic                         pixel_stall,
  input  logic [10:0]                  frame_width,
  input  logic [11:0]                  frame_height,
  input  logic                         q_full,
  output logic                         push,
  output pvef_pkg::job_t               job,
  output logic [$clog2(MAX_WIDTH)-1:0] idx
);

  import pvef_pkg::*;

  localparam int IDX_W = $clog2(MAX_WIDTH);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

  logic [IDX_W-1:0] column_counter;
  logic [11:0]      row_counter;
  logic [IDX_W-1:0] column_counter_next;
  logic [11:0]      row_counter_next;

  logic [WW-1:0] fw_ext;
  logic [WW-1:0] w;
  logic [11:0]   h;
  logic [WW-1:0] col0;
  logic [11:0]   row0;
  logic [12:0]   r1;
  logic [WW-1:0] c;
  logic [11:0]   r;
  logic [WW-1:0] c_inc;
  logic [12:0]   r_inc;
  logic [WW-1:0] c_dec;

  assign pixel_stall = q_full;
  assign push        = pixel_valid && !q_full;

  // effective frame sizes
  always_comb begin
    fw_ext = WW'(frame_width);
    if (fw_ext < WW'(MIN_DIM)) begin
      w = WW'(MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    h = (frame_height < 12'(MIN_DIM)) ? 12'(MIN_DIM) : frame_height;
  end

  // position of this pixel, then where the next one lands
  always_comb begin
    col0 = pixel.frame_start ? '0 : WW'(column_counter);
    row0 = pixel.frame_start ? '0 : row_counter;
    if (col0 >= w) begin
      c  = '0;
      r1 = {1'b0, row0} + 13'd1;
    end else begin
      c  = col0;
      r1 = {1'b0, row0};
    end
    r = (r1 >= {1'b0, h}) ? '0 : r1[11:0];

    c_inc = c + WW'(1);
    r_inc = {1'b0, r} + 13'd1;
    if (c_inc >= w) begin
      column_counter_next = '0;
      row_counter_next    = (r_inc >= {1'b0, h}) ? '0 : r_inc[11:0];
    end else begin
      column_counter_next = c_inc[IDX_W-1:0];
      row_counter_next    = r;
    end

    c_dec     = c - WW'(1);
    idx       = c[IDX_W-1:0];
    job.px    = {pixel.blue, pixel.green, pixel.red};
    job.emit  = (r >= 12'd2) && (c >= WW'(2));
    job.row   = r - 12'd1;
    job.col   = c_dec[9:0];
    job.done  = (r == h - 12'd1) && (c == w - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (push) begin
      column_counter <= column_counter_next;
      row_counter    <= row_counter_next;
    end
  end

endmodule

/* design/pvef_queue.sv */
// Short FIFO between the front end and the back end.
module pvef_queue #(
  parameter int WIDTH = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  import pvef_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

/* design/pvef_back.sv */
// Back end: line store, 3x3 window, gradient, divide by three, output register.
module pvef_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  pvef_pkg::job_t               q_job,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_idx,
  output logic                         q_pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output pvef_pkg::result_t            result
);

  import pvef_pkg::*;

  localparam int IDX_W = $clog2(MAX_WIDTH);

  // whole pipeline moves together when the output register can take a transfer
  logic en;

  // stage 1: line store data arrives
  logic             s1_valid;
  job_t             s1_job;
  logic [IDX_W-1:0] s1_idx;

  // line store: {older, newer} per column
  logic [47:0] ram_q;
  logic [47:0] line_rd;
  logic        fwd_hit;
  logic [47:0] fwd_data;
  logic [23:0] older_rd;
  logic [23:0] newer_rd;

  // window: right is column c-1, left is column c-2; rows old, new, current
  logic [23:0] win_r [3];
  logic [23:0] win_l [3];

  logic signed [10:0] diff [3];

  // stage 2: signed differences
  logic               s2_valid;
  logic               s2_emit;
  logic [11:0]        s2_row;
  logic [9:0]         s2_col;
  logic               s2_done;
  logic signed [10:0] s2_diff [3];

  logic [9:0]  mag  [3];
  logic [19:0] prod [3];
  logic [7:0]  quot [3];

  assign en    = !result_valid || !result_stall;
  assign q_pop = en && q_valid;

  pvef_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_idx),
    .wdata ({newer_rd, s1_job.px}),
    .re    (q_pop),
    .raddr (q_idx),
    .rdata (ram_q)
  );

  // bypass the write of the item ahead when it hits the same column
  assign line_rd  = fwd_hit ? fwd_data : ram_q;
  assign older_rd = line_rd[47:24];
  assign newer_rd = line_rd[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (en) begin
      fwd_hit <= q_pop && s1_valid && (q_idx == s1_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_data <= {newer_rd, s1_job.px};
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_job <= q_job;
      s1_idx <= q_idx;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= '0;
        win_l[i] <= '0;
      end
    end else if (en && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win_l[i] <= win_r[i];
      end
      win_r[0] <= older_rd;
      win_r[1] <= newer_rd;
      win_r[2] <= s1_job.px;
    end
  end

  // right column sum minus left column sum, per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({1'b0, 10'(older_rd[8*k +: 8]) + 10'(newer_rd[8*k +: 8])
                               + 10'(s1_job.px[8*k +: 8])})
              - $signed({1'b0, 10'(win_l[0][8*k +: 8]) + 10'(win_l[1][8*k +: 8])
                               + 10'(win_l[2][8*k +: 8])});
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_emit <= s1_job.emit;
      s2_row  <= s1_job.row;
      s2_col  <= s1_job.col;
      s2_done <= s1_job.done;
      for (int k = 0; k < 3; k++) begin
        s2_diff[k] <= diff[k];
      end
    end
  end

  // magnitude, then divide by three through the reciprocal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = s2_diff[k][10] ? 10'(-s2_diff[k]) : s2_diff[k][9:0];
      prod[k] = 20'(mag[k]) * 20'(RECIP3);
      quot[k] = prod[k][RECIP3_SHIFT +: 8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_red    <= quot[0];
      result.out_green  <= quot[1];
      result.out_blue   <= quot[2];
      result.out_row    <= s2_row;
      result.out_col    <= s2_col;
      result.frame_done <= s2_done;
    end
  end

  // a bypass is only armed for an item that sits in stage 1
  a_fwd_has_item: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("line store bypass armed without an item in stage 1");

  // a stalled back end holds every stage
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s1_valid) && $stable(s2_valid))
    else $error("back end stages moved while stalled");

  // gradient magnitude of an interior centre never exceeds three full-scale bytes
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_emit |-> (mag[0] <= 10'd765) && (mag[1] <= 10'd765)
                            && (mag[2] <= 10'd765))
    else $error("gradient magnitude out of range");

  // a pop needs a slot in stage 1, granted only when the pipeline moves
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_valid)
    else $error("popped job did not reach stage 1");

endmodule

/* verif/tb_prewitt_vertical_edge_filter.sv */
// Self-checking testbench for the Prewitt vertical-edge filter: directed and random pixel streams.
`timescale 1ns / 100ps

module tb_prewitt_vertical_edge_filter;
  import pvef_pkg::*;

  localparam int MAXW          = 1024;
  localparam int SETTLE_CYCLES = 16;       // back-end pipeline plus pixel queue, with margin
  localparam int CYCLE_LIMIT   = 200000;
  localparam int NUM_PHASES    = 9;

  // One row of the directed stimulus; typed_in selects the literal in want
  typedef struct packed {
    pixel_t  px;
    logic    typed_in;
    result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  pixel_t                pixel = '0;
  logic                  pixel_stall;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: sizes, the two rows above, the two columns to the left, position
  logic [10:0] width_reg  = FRAME_WIDTH_RST;
  logic [11:0] height_reg = FRAME_HEIGHT_RST;
  logic [23:0] two_up [MAXW];
  logic [23:0] one_up [MAXW];
  logic [23:0] cols_seen [6] = '{default: '0};
  int          pos_row = 0;
  int          pos_col = 0;

  result_t     gradients_due [$];
  int          send_idle_pct = 0;
  int          result_stall_pct = 0;
  int          pixels_sent = 0;
  int          results_checked = 0;
  int          frame_ends = 0;
  int          size_settings = 0;
  int          errors = 0;
  int unsigned cycle_count = 0;

  // Random phases: width and height register values and pixel count
  logic [11:0] phase_width [NUM_PHASES] = '{12'd3, 12'd2, 12'd0, 12'd5, 12'd8,
                                            12'd17, 12'd1, 12'd12, 12'd4};
  logic [11:0] phase_height [NUM_PHASES] = '{12'd3, 12'd1, 12'd0, 12'd4, 12'd4095,
                                             12'd6, 12'd7, 12'd2, 12'd3};
  int          phase_pixels [NUM_PHASES] = '{50, 30, 30, 50, 60, 110, 30, 40, 40};

  // 3x3 frames: one with full-scale gradients, one run on without a start mark with
  // full-scale gradients in red and green, one cut short by a restart, then one with mixed values
  stim_row_t directed_rows [28] = '{
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b0, '0},
    '{'{8'd128, 8'd64,  8'd32,  1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd1,   8'd2,   8'd3,   1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '0},
    '{'{8'd200, 8'd100, 8'd50,  1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 12'd1, 10'd1, 1'b1}},
    '{'{8'd255, 8'd0,   8'd77,  1'b0}, 1'b0, '0},
    '{'{8'd30,  8'd40,  8'd50,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd77,  1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd77,  1'b0}, 1'b0, '0},
    '{'{8'd30,  8'd40,  8'd50,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd77,  1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd77,  1'b0}, 1'b0, '0},
    '{'{8'd30,  8'd40,  8'd50,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd77,  1'b0}, 1'b1,
      '{8'd255, 8'd255, 8'd0,   12'd1, 10'd1, 1'b1}},
    '{'{8'd9,   8'd9,   8'd9,   1'b1}, 1'b0, '0},
    '{'{8'd200, 8'd13,  8'd7,   1'b1}, 1'b0, '0},
    '{'{8'd50,  8'd50,  8'd50,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd14,  8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd1,   8'd250, 8'd100, 1'b0}, 1'b0, '0},
    '{'{8'd7,   8'd8,   8'd9,   1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd1,   8'd3,   1'b0}, 1'b0, '0},
    '{'{8'd99,  8'd0,   8'd128, 1'b0}, 1'b0, '0},
    '{'{8'd60,  8'd61,  8'd62,  1'b0}, 1'b0, '0},
    '{'{8'd50,  8'd128, 8'd64,  1'b0}, 1'b0, '0}
  };

  prewitt_vertical_edge_filter #(
    .MAX_WIDTH(MAXW)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .pixel_stall (pixel_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached, %0d results outstanding",
               CYCLE_LIMIT, gradients_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Effective sizes after saturation
  function automatic int frame_w();
    int w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int frame_h();
    int h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    return h;
  endfunction

  // |right column sum - left column sum| / 3 for one channel
  function automatic logic [7:0] third_of_diff(input logic [23:0] r0, r1, r2, l0, l1, l2,
                                               input int ch);
    int v;
    v = int'(r0[8*ch +: 8]) + int'(r1[8*ch +: 8]) + int'(r2[8*ch +: 8])
      - int'(l0[8*ch +: 8]) - int'(l1[8*ch +: 8]) - int'(l2[8*ch +: 8]);
    if (v < 0) v = -v;
    return 8'(v / 3);
  endfunction

  // Takes one pixel into the predictor; returns 1 with the gradient when a centre completes
  function automatic logic predict_gradient(input pixel_t p, output result_t g);
    int          w, h, r, c, k;
    logic [23:0] px, up2, up1;
    logic        hit;
    w = frame_w();
    h = frame_h();
    if (p.frame_start) begin
      pos_row = 0;
      pos_col = 0;
    end
    // position may lie outside a frame that was made smaller
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    k = c % MAXW;
    px = {p.blue, p.green, p.red};
    up2 = two_up[k];
    up1 = one_up[k];
    hit = (r >= 2) && (c >= 2);
    g = '0;
    if (hit) begin
      g.out_red   = third_of_diff(up2, up1, px, cols_seen[3], cols_seen[4], cols_seen[5], 0);
      g.out_green = third_of_diff(up2, up1, px, cols_seen[3], cols_seen[4], cols_seen[5], 1);
      g.out_blue  = third_of_diff(up2, up1, px, cols_seen[3], cols_seen[4], cols_seen[5], 2);
      g.out_row    = 12'(r - 1);
      g.out_col    = 10'(c - 1);
      g.frame_done = (r == h - 1) && (c == w - 1);
    end
    // shift line stores and window
    two_up[k] = up1;
    one_up[k] = px;
    cols_seen[3] = cols_seen[0];
    cols_seen[4] = cols_seen[1];
    cols_seen[5] = cols_seen[2];
    cols_seen[0] = up2;
    cols_seen[1] = up1;
    cols_seen[2] = px;
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
    return hit;
  endfunction

  // Bytes lean towards the extremes
  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t random_pixel(input logic start);
    pixel_t p;
    p.red = random_byte();
    p.green = random_byte();
    p.blue = random_byte();
    p.frame_start = start;
    return p;
  endfunction

  task automatic report(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  want r=%0d g=%0d b=%0d row=%0d col=%0d done=%0d", want.out_red,
               want.out_green, want.out_blue, want.out_row, want.out_col, want.frame_done);
      $display("  got  r=%0d g=%0d b=%0d row=%0d col=%0d done=%0d", got.out_red,
               got.out_green, got.out_blue, got.out_row, got.out_col, got.frame_done);
    end
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    result_stall_pct = stall_pct;
  endtask

  // Result side: random stall, check each transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    result_stall <= ($urandom_range(99) < result_stall_pct);
    if (!rst && result_valid && !result_stall) begin
      if (gradients_due.size() == 0) begin
        report("Result with nothing expected", '0, result);
      end else begin
        want = gradients_due.pop_front();
        results_checked++;
        if (result.frame_done === 1'b1) frame_ends++;
        if (result.out_red !== want.out_red || result.out_green !== want.out_green ||
            result.out_blue !== want.out_blue || result.out_row !== want.out_row ||
            result.out_col !== want.out_col || result.frame_done !== want.frame_done) begin
          report("Result mismatch", want, result);
        end
      end
    end
  end

  // Hold the pixel side until every expected result has been seen
  task automatic wait_for_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (gradients_due.size() != 0);
  endtask

  // Drained and quiet: safe for register writes and for the end of the run
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [11:0] wdata, input logic [11:0] hdata);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= wdata;
    @(posedge clk);
    width_reg = wdata[10:0];
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= hdata;
    @(posedge clk);
    height_reg = hdata;
    cfg_write <= 1'b0;
    size_settings++;
  endtask

  // One pixel transfer; the expectation is the literal or the predictor's answer
  task automatic send_pixel(input pixel_t p, input logic typed_in, input result_t literal);
    result_t predicted;
    logic    hit;
    if (pixels_sent % 500 == 250) wait_for_results();
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
    hit = predict_gradient(p, predicted);
    if (typed_in) gradients_due.push_back(literal);
    else if (hit) gradients_due.push_back(predicted);
  endtask

  task automatic stream(input int n, input logic start);
    for (int i = 0; i < n; i++) begin
      send_pixel(random_pixel(start && i == 0), 1'b0, '0);
    end
  endtask

  // Mostly whole frames, some cut short by a restart, some running on without a start mark.
  // A phase only carries on the open frame when the width did not grow, so no centre
  // reads a line store entry that was never written.
  task automatic random_phase(input logic [11:0] wdata, input logic [11:0] hdata,
                              input int n_pixels);
    int   prior_w, w, h, len, left, pick;
    logic carry, start;
    prior_w = frame_w();
    settle();
    write_sizes(wdata, hdata);
    w = frame_w();
    h = frame_h();
    carry = (w <= prior_w) && ($urandom_range(1) == 1);
    left = n_pixels;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 80) len = w * h;
      else if (pick < 92) len = $urandom_range(1, 2 * w);
      else len = $urandom_range(w, w * h);
      start = (left == n_pixels) ? !carry : (pick < 92);
      if (len > left) len = left;
      stream(len, start);
      left -= len;
    end
  endtask

  // Stimulus
  initial begin
    set_idling(33, 64);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sizes left at their reset values: two rows and part of a third
    stream(2 * int'(FRAME_WIDTH_RST) + 8, 1'b1);

    settle();
    write_sizes(12'd3, 12'd3);
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].typed_in, directed_rows[i].want);
    end

    for (int i = 0; i < NUM_PHASES; i++) begin
      if (i == 3) set_idling(64, 33);
      if (i == 6) set_idling(0, 0);
      random_phase(phase_width[i], phase_height[i], phase_pixels[i]);
    end

    // widest width setting with bit 11 of the data set, height raised from zero to the
    // minimum: part of a first row, no centre completes
    settle();
    write_sizes(12'hFFF, 12'h000);
    stream(20, 1'b1);

    settle();
    $display("Sent %0d pixels under %0d size settings, reset sizes and saturated sizes",
             pixels_sent, size_settings);
    $display("Checked %0d results, %0d with end of frame, %0d errors",
             results_checked, frame_ends, errors);
    if (errors == 0 && gradients_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pvef_pkg.sv
design/pvef_ram.sv
design/pvef_front.sv
design/pvef_queue.sv
design/pvef_back.sv
design/prewitt_vertical_edge_filter.sv
verif/tb_prewitt_vertical_edge_filter.sv
